// ===== src/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned StatW  = 4;
	localparam int unsigned PosW   = 6;

	// header layout: vv-<32 trace-id>-<16 parent-id>-ff
	localparam logic [PosW-1:0] HdrLen = PosW'(55);
	localparam logic [PosW-1:0] PosSat = PosW'(56);
	localparam logic [PosW-1:0] DelimA = PosW'(2);
	localparam logic [PosW-1:0] DelimB = PosW'(35);
	localparam logic [PosW-1:0] DelimC = PosW'(52);

	localparam logic [CharW-1:0] ChDash = 8'h2d;
	localparam logic [CharW-1:0] ChZero = 8'h30;
	localparam logic [CharW-1:0] ChNine = 8'h39;
	localparam logic [CharW-1:0] ChLowA = 8'h61;
	localparam logic [CharW-1:0] ChLowF = 8'h66;

	typedef enum logic [StatW-1:0] {
		ST_OK          = 4'd0,
		ST_LENGTH      = 4'd1,
		ST_DELIM       = 4'd2,
		ST_VERSION_HEX = 4'd3,
		ST_TRACE_HEX   = 4'd4,
		ST_PARENT_HEX  = 4'd5,
		ST_FLAGS_HEX   = 4'd6,
		ST_VERSION_FF  = 4'd7,
		ST_TRACE_ZERO  = 4'd8,
		ST_PARENT_ZERO = 4'd9
	} status_t;

	function automatic logic is_low_hex(input logic [CharW-1:0] c);
		return ((c >= ChZero) && (c <= ChNine)) || ((c >= ChLowA) && (c <= ChLowF));
	endfunction

endpackage

// ===== src/trace_context_header_checker_core.sv =====
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------
// input    | char_valid / char_ready    | char_byte[7:0], last_char
// output   | status_valid / status_ready| status[3:0]
//
// One character per cycle while no final character is stalled: a word sits in the
// input register, is checked against the running state and, if final, loads the
// status register. A status is loaded when its final character leaves the input
// register, which holds that character while the previous status is still unread.
// Reset returns the counter and flags to their start values and clears both valid bits.
// A waiting status stalls only a final character held in the input register;
// other characters keep flowing while the status is unread.
module trace_context_header_checker_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_ready,
	input  logic [tcc_pkg::CharW-1:0] char_byte,
	input  logic                      last_char,
	output logic                      status_valid,
	input  logic                      status_ready,
	output logic [tcc_pkg::StatW-1:0] status
);
	import tcc_pkg::*;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	logic [PosW-1:0]  pos_q;
	status_t          first_err_q;
	logic             err_seen_q;
	logic             trace_zero_q;
	logic             parent_zero_q;
	logic             ver_first_f_q;
	logic             ver_ff_q;

	logic             out_valid_q;
	status_t          status_q;

	logic             advance;

	logic [PosW-1:0]  pos_n;
	status_t          first_err_n;
	logic             err_seen_n;
	logic             trace_zero_n;
	logic             parent_zero_n;
	logic             ver_first_f_n;
	logic             ver_ff_n;
	status_t          status_n;

	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || status_ready);
	assign char_ready = !valid_s1 || advance;

	always_comb begin
		logic    examine;
		logic    delim;
		logic    hex;
		status_t code;

		pos_n         = pos_q;
		first_err_n   = first_err_q;
		err_seen_n    = err_seen_q;
		trace_zero_n  = trace_zero_q;
		parent_zero_n = parent_zero_q;
		ver_first_f_n = ver_first_f_q;
		ver_ff_n      = ver_ff_q;

		examine = (pos_q < HdrLen) && !err_seen_q;
		delim   = (pos_q == DelimA) || (pos_q == DelimB) || (pos_q == DelimC);
		hex     = is_low_hex(char_s1);

		if (pos_q < DelimA) begin
			code = ST_VERSION_HEX;
		end else if (pos_q < DelimB) begin
			code = ST_TRACE_HEX;
		end else if (pos_q < DelimC) begin
			code = ST_PARENT_HEX;
		end else begin
			code = ST_FLAGS_HEX;
		end

		if (examine) begin
			if (delim) begin
				if (char_s1 != ChDash) begin
					err_seen_n  = 1'b1;
					first_err_n = ST_DELIM;
				end
			end else if (!hex) begin
				err_seen_n  = 1'b1;
				first_err_n = code;
			end else begin
				if (char_s1 != ChZero) begin
					if ((pos_q > DelimA) && (pos_q < DelimB)) begin
						trace_zero_n = 1'b0;
					end else if ((pos_q > DelimB) && (pos_q < DelimC)) begin
						parent_zero_n = 1'b0;
					end
				end
				if (pos_q == '0) begin
					ver_first_f_n = (char_s1 == ChLowF);
				end else if (pos_q == PosW'(1)) begin
					ver_ff_n = ver_first_f_q && (char_s1 == ChLowF);
				end
			end
		end

		// saturate past the header length so overlong input reads as wrong length
		if (pos_q < PosSat) begin
			pos_n = pos_q + PosW'(1);
		end

		if (pos_n != HdrLen) begin
			status_n = ST_LENGTH;
		end else if (err_seen_n) begin
			status_n = first_err_n;
		end else if (ver_ff_n) begin
			status_n = ST_VERSION_FF;
		end else if (trace_zero_n) begin
			status_n = ST_TRACE_ZERO;
		end else if (parent_zero_n) begin
			status_n = ST_PARENT_ZERO;
		end else begin
			status_n = ST_OK;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_byte;
			last_s1 <= last_char;
		end
	end

	// running header state; return to reset after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			first_err_q   <= ST_OK;
			err_seen_q    <= 1'b0;
			trace_zero_q  <= 1'b1;
			parent_zero_q <= 1'b1;
			ver_first_f_q <= 1'b0;
			ver_ff_q      <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q         <= '0;
				first_err_q   <= ST_OK;
				err_seen_q    <= 1'b0;
				trace_zero_q  <= 1'b1;
				parent_zero_q <= 1'b1;
				ver_first_f_q <= 1'b0;
				ver_ff_q      <= 1'b0;
			end else begin
				pos_q         <= pos_n;
				first_err_q   <= first_err_n;
				err_seen_q    <= err_seen_n;
				trace_zero_q  <= trace_zero_n;
				parent_zero_q <= parent_zero_n;
				ver_first_f_q <= ver_first_f_n;
				ver_ff_q      <= ver_ff_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (status_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_n;
		end
	end

	assign status_valid = out_valid_q;
	assign status       = status_q;

endmodule

// ===== tb/sv/trace_context_header_checker_core_tb.sv =====
`timescale 1ns / 1ps

module trace_context_header_checker_core_tb;
	import tcc_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned TailCycles = 12;

	// Running copy of the header check; one expected status per final character
	class header_status_tracker;
		logic [PosW-1:0] pos;
		status_t         first_err;
		bit              err_seen;
		bit              trace_zero;
		bit              parent_zero;
		bit              ver_first_f;
		bit              ver_ff;
		status_t         expected_status_q[$];
		int              errors;
		int              checked;
		int              code_hits[10];

		function new();
			errors = 0;
			checked = 0;
			foreach (code_hits[i])
				code_hits[i] = 0;
			clear_header();
		endfunction

		function void clear_header();
			pos         = '0;
			first_err   = ST_OK;
			err_seen    = 1'b0;
			trace_zero  = 1'b1;
			parent_zero = 1'b1;
			ver_first_f = 1'b0;
			ver_ff      = 1'b0;
		endfunction

		function void take_char(logic [CharW-1:0] c, logic fin);
			bit      hex;
			status_t code;
			hex = (c[7:4] == 4'h3 && c[3:0] <= 4'd9) ||
			      (c[7:4] == 4'h6 && c[3:0] >= 4'd1 && c[3:0] <= 4'd6);
			if (pos < HdrLen && !err_seen) begin
				if (pos == DelimA || pos == DelimB || pos == DelimC) begin
					if (c != ChDash) begin
						err_seen  = 1'b1;
						first_err = ST_DELIM;
					end
				end else if (!hex) begin
					err_seen  = 1'b1;
					first_err = (pos < DelimA) ? ST_VERSION_HEX :
					            (pos < DelimB) ? ST_TRACE_HEX :
					            (pos < DelimC) ? ST_PARENT_HEX : ST_FLAGS_HEX;
				end else begin
					if (c != ChZero) begin
						if (pos > DelimA && pos < DelimB)
							trace_zero = 1'b0;
						else if (pos > DelimB && pos < DelimC)
							parent_zero = 1'b0;
					end
					if (pos == 0)
						ver_first_f = (c == ChLowF);
					else if (pos == 1)
						ver_ff = ver_first_f && (c == ChLowF);
				end
			end
			if (pos < PosSat)
				pos = pos + 1'b1;
			if (fin) begin
				if (pos != HdrLen)
					code = ST_LENGTH;
				else if (err_seen)
					code = first_err;
				else if (ver_ff)
					code = ST_VERSION_FF;
				else if (trace_zero)
					code = ST_TRACE_ZERO;
				else if (parent_zero)
					code = ST_PARENT_ZERO;
				else
					code = ST_OK;
				expected_status_q.push_back(code);
				clear_header();
			end
		endfunction

		function void check_status(logic [StatW-1:0] actual);
			status_t want;
			if (expected_status_q.size() == 0) begin
				$error("status word with none expected: actual %0d", actual);
				errors++;
				return;
			end
			want = expected_status_q.pop_front();
			checked++;
			if (actual !== want) begin
				$error("status mismatch: expected %0d, actual %0d", want, actual);
				errors++;
			end else begin
				code_hits[want]++;
			end
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction

		function int codes_reached();
			int n;
			n = 0;
			foreach (code_hits[i])
				if (code_hits[i] != 0)
					n++;
			return n;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             char_valid;
	logic             char_ready;
	logic [CharW-1:0] char_byte;
	logic             last_char;
	logic             status_valid;
	logic             status_ready;
	logic [StatW-1:0] status;

	header_status_tracker tracker;
	logic [CharW-1:0]     hdr[$];
	bit                   quiet;
	bit                   idle_on;
	int unsigned          cycle_count;
	int                   chars_sent;
	int                   headers_sent;

	trace_context_header_checker_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_byte    (char_byte),
		.last_char    (last_char),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && status_valid && status_ready)
			tracker.check_status(status);

	// Receiver: stall in bursts, with free-running stretches in between
	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		status_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				status_ready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				status_ready <= 1'b0;
			end else if (run_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				status_ready <= 1'b0;
			end else begin
				if (run_left == 0)
					run_left = $urandom_range(1, 40);
				else
					run_left--;
				status_ready <= 1'b1;
			end
		end
	end

	function automatic logic [CharW-1:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		return (v < 10) ? ChZero + CharW'(v) : ChLowA + CharW'(v - 10);
	endfunction

	function automatic logic [CharW-1:0] rand_odd_char();
		logic [CharW-1:0] near[11];
		near = '{ChDash, 8'h2f, 8'h3a, 8'h40, 8'h41, 8'h46, 8'h47, 8'h60, 8'h67,
		         ChLowF, ChZero};
		if ($urandom_range(0, 1) == 0)
			return CharW'($urandom_range(0, 255));
		return near[$urandom_range(0, 10)];
	endfunction

	// Well-formed header with random digits; version never ff here
	function automatic void build_good();
		hdr.delete();
		do begin
			hdr.delete();
			hdr.push_back(rand_hex());
			hdr.push_back(rand_hex());
		end while (hdr[0] == ChLowF && hdr[1] == ChLowF);
		hdr.push_back(ChDash);
		repeat (32) hdr.push_back(rand_hex());
		hdr.push_back(ChDash);
		repeat (16) hdr.push_back(rand_hex());
		hdr.push_back(ChDash);
		repeat (2) hdr.push_back(rand_hex());
	endfunction

	function automatic void fill_span(int lo, int hi, logic [CharW-1:0] c);
		for (int i = lo; i <= hi; i++)
			hdr[i] = c;
	endfunction

	function automatic void resize_header(int n);
		while (hdr.size() > n)
			void'(hdr.pop_back());
		while (hdr.size() < n)
			hdr.push_back(CharW'($urandom_range(0, 255)));
	endfunction

	task automatic send_char(input logic [CharW-1:0] c, input logic fin);
		int gap;
		gap = 0;
		if (!quiet && idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 10);
		if (gap != 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte  <= c;
		last_char  <= fin;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		tracker.take_char(c, fin);
		chars_sent++;
	endtask

	task automatic send_header();
		idle_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < hdr.size(); i++)
			send_char(hdr[i], i == hdr.size() - 1);
		headers_sent++;
	endtask

	initial begin
		int mode;
		tracker      = new();
		quiet        = 1'b0;
		idle_on      = 1'b0;
		cycle_count  = 0;
		chars_sent   = 0;
		headers_sent = 0;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_byte  <= '0;
		last_char  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clean header, version 00 with flags ff, version f then not f
		build_good();
		send_header();
		build_good();
		fill_span(0, 1, ChZero);
		fill_span(53, 54, ChLowF);
		send_header();
		build_good();
		hdr[0] = ChLowF;
		hdr[1] = 8'h65;
		send_header();
		// forbidden version, all-zero ids, and their order
		build_good();
		fill_span(0, 1, ChLowF);
		send_header();
		build_good();
		fill_span(3, 34, ChZero);
		send_header();
		build_good();
		fill_span(36, 51, ChZero);
		send_header();
		build_good();
		fill_span(0, 1, ChLowF);
		fill_span(3, 34, ChZero);
		fill_span(36, 51, ChZero);
		send_header();
		// a bad delimiter at each of the three places
		build_good();
		hdr[DelimA] = 8'h5f;
		send_header();
		build_good();
		hdr[DelimB] = 8'h00;
		send_header();
		build_good();
		hdr[DelimC] = 8'hff;
		send_header();
		// non-hex digit in each field, at the edges of the hex ranges
		build_good();
		hdr[0] = 8'h41;
		send_header();
		build_good();
		hdr[34] = 8'h67;
		send_header();
		build_good();
		hdr[36] = 8'h2f;
		hdr[40] = 8'h3a;
		send_header();
		build_good();
		hdr[53] = 8'h60;
		send_header();
		build_good();
		hdr[54] = 8'h00;
		send_header();
		// first error in order wins; a character error beats version ff
		build_good();
		hdr[1] = 8'h47;
		hdr[DelimA] = 8'h2b;
		send_header();
		build_good();
		hdr[10] = 8'h80;
		hdr[DelimB] = 8'h30;
		send_header();
		build_good();
		fill_span(0, 1, ChLowF);
		hdr[40] = 8'hff;
		send_header();
		// wrong lengths: short, a single character, short with an error, long
		build_good();
		resize_header(54);
		send_header();
		hdr.delete();
		hdr.push_back(8'hff);
		send_header();
		build_good();
		hdr[0] = 8'h00;
		resize_header(20);
		send_header();
		build_good();
		resize_header(56);
		send_header();
		build_good();
		resize_header(70);
		send_header();

		// random: well-formed headers mixed with forbidden versions, zero ids, corrupted, misframed and noise
		while (chars_sent < 1950 || headers_sent < 60) begin
			if (chars_sent >= 1700 && headers_sent >= 50)
				quiet = 1'b1;
			mode = $urandom_range(0, 99);
			build_good();
			if (mode < 30) begin
				// leave as is
			end else if (mode < 38) begin
				fill_span(0, 1, ChLowF);
			end else if (mode < 46) begin
				if ($urandom_range(0, 1) == 0)
					fill_span(3, 34, ChZero);
				else
					fill_span(36, 51, ChZero);
				if ($urandom_range(0, 3) == 0)
					hdr[$urandom_range(3, 51)] = ChZero + CharW'($urandom_range(1, 9));
			end else if (mode < 70) begin
				hdr[$urandom_range(0, 54)] = rand_odd_char();
			end else if (mode < 80) begin
				hdr[$urandom_range(0, 54)] = rand_odd_char();
				hdr[$urandom_range(0, 54)] = rand_odd_char();
				if ($urandom_range(0, 1) == 0)
					fill_span(0, 1, ChLowF);
			end else if (mode < 90) begin
				if ($urandom_range(0, 1) == 0)
					resize_header($urandom_range(1, 54));
				else
					resize_header($urandom_range(56, 70));
			end else begin
				hdr.delete();
				repeat ($urandom_range(1, 60))
					hdr.push_back(CharW'($urandom_range(0, 255)));
			end
			send_header();
		end
		char_valid <= 1'b0;
		quiet = 1'b1;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d headers in %0d characters; %0d statuses checked.",
		         headers_sent, chars_sent, tracker.checked);
		$display("Distinct status codes matched: %0d of 10.", tracker.codes_reached());
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tcc_pkg.sv
src/trace_context_header_checker_core.sv
tb/sv/trace_context_header_checker_core_tb.sv
